### src/atlr_pkg.sv
// Shared types and constants for the antialiased thick line rasterizer.
// Used by the channel interfaces and by every module of the block.
package atlr_pkg;

  localparam int COORD_BITS     = 10;
  localparam int FRAC_BITS      = 8;
  localparam int MAX_THICKNESS  = 7;
  localparam int THICK_BITS     = 3;
  localparam int INTENSITY_BITS = 8;
  localparam int HALF_BITS      = 2;
  localparam int PIX_BITS       = 12;
  localparam int ADDR_BITS      = 20;
  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int ROW_BITS       = COORD_BITS + FRAC_BITS;
  localparam int GRAD_BITS      = COORD_BITS;
  localparam int DIV_STEPS      = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
  localparam int OFS_BITS       = 3;

  localparam logic [INTENSITY_BITS-1:0] ALPHA_FULL = 8'hFF;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DISCARD,
    CMD_ADVANCE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                       kind;
    logic                            steep;
    logic                            point_only;
    logic [COORD_BITS-1:0]           column;
    logic [COORD_BITS-1:0]           last_column;
    logic [COORD_BITS-1:0]           row_start;
    logic signed [GRAD_BITS-1:0]     gradient;
    logic [INTENSITY_BITS-1:0]       brightness;
    logic [HALF_BITS-1:0]            half_width;
    logic                            erase;
  } cmd_t;

  typedef struct packed {
    logic signed [PIX_BITS-1:0]      x;
    logic signed [PIX_BITS-1:0]      y;
    logic [INTENSITY_BITS-1:0]       alpha;
    logic                            erase;
    logic                            last;
    logic                            done;
  } pix_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_FETCH,
    B_EMIT
  } back_state_t;

endpackage

### src/atlr_intf.sv
// Channel interfaces of the rasterizer: line commands in, pixels out.
// Depends on atlr_pkg for field widths.
interface atlr_line_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    func;
  logic [atlr_pkg::COORD_BITS-1:0]         start_x;
  logic [atlr_pkg::COORD_BITS-1:0]         start_y;
  logic [atlr_pkg::COORD_BITS-1:0]         end_x;
  logic [atlr_pkg::COORD_BITS-1:0]         end_y;
  logic [atlr_pkg::INTENSITY_BITS-1:0]     intensity;
  logic [atlr_pkg::THICK_BITS-1:0]         width_px;
  logic                                    erase;

  modport source (output valid, func, start_x, start_y, end_x, end_y, intensity,
                  width_px, erase, input ready);
  modport sink (input valid, func, start_x, start_y, end_x, end_y, intensity,
                width_px, erase, output ready);
endinterface

interface atlr_pixel_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [atlr_pkg::PIX_BITS-1:0]    pixel_x;
  logic signed [atlr_pkg::PIX_BITS-1:0]    pixel_y;
  logic [atlr_pkg::ADDR_BITS-1:0]          pixel_address;
  logic                                    in_frame;
  logic [atlr_pkg::INTENSITY_BITS-1:0]     alpha;
  logic                                    erase_pixel;
  logic                                    last;
  logic                                    line_done;

  modport source (output valid, pixel_x, pixel_y, pixel_address, in_frame, alpha,
                  erase_pixel, last, line_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_address, in_frame, alpha,
                erase_pixel, last, line_done, output ready);
endinterface

### src/antialiased_thick_line_rasterizer.sv
// Antialiased thick line rasterizer: top level with frame registers and module wiring.
// Depends on atlr_pkg, atlr_intf, atlr_front, atlr_queue, atlr_back and atlr_emit.
//
// A load transaction sets up a line and emits nothing; the front end accepts it, runs nine
// divider steps at one gradient bit per cycle for a line of more than one point, then writes
// the queue, while the back end keeps drawing earlier commands.
// Each advance transaction yields one pixel per cycle, while the output is not stalled,
// after its queue fetch: 2h+1 pixels per column, 2h+2 when the minor position has a fraction,
// and (2h+1)^2 for a single point, where h is the half width (at most 3, so at most 8 and 49
// pixels). The pixel output port, one pixel per cycle, sets the drawing rate.
module antialiased_thick_line_rasterizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [atlr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [atlr_pkg::CFG_BITS-1:0]         cfg_data,
  atlr_line_if.sink                             line_in,
  atlr_pixel_if.source                          pixels
);

  logic [atlr_pkg::CFG_BITS-1:0] frame_width;
  logic [atlr_pkg::CFG_BITS-1:0] frame_height;

  logic            q_push, q_full, q_pop, q_avail;
  atlr_pkg::cmd_t  q_din, q_dout;
  logic            pix_valid, pix_ready;
  atlr_pkg::pix_t  pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= atlr_pkg::FRAME_WIDTH_RESET;
      frame_height <= atlr_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        atlr_pkg::CFG_FRAME_WIDTH:  frame_width <= cfg_data;
        atlr_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  atlr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .line_in (line_in),
    .q_push  (q_push),
    .q_cmd   (q_din),
    .q_full  (q_full)
  );

  atlr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .avail (q_avail)
  );

  atlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_cmd     (q_dout),
    .q_pop     (q_pop),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_ready (pix_ready)
  );

  atlr_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix          (pix),
    .pix_ready    (pix_ready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixels       (pixels)
  );

endmodule

### src/atlr_front.sv
// Front end: accepts line transactions, orders endpoints and runs the gradient divider.
// Depends on atlr_pkg and atlr_line_if; feeds commands to atlr_queue.
module atlr_front (
  input  logic              clk,
  input  logic              rst,
  atlr_line_if.sink         line_in,
  output logic              q_push,
  output atlr_pkg::cmd_t    q_cmd,
  input  logic              q_full
);

  atlr_pkg::front_state_t state, state_next;
  atlr_pkg::cmd_t         cmd;

  logic [atlr_pkg::COORD_BITS:0]       rem;
  logic [atlr_pkg::COORD_BITS-1:0]     divisor;
  logic [atlr_pkg::DIV_STEPS-1:0]      quo;
  logic [atlr_pkg::DIV_CNT_BITS-1:0]   step;
  logic                                dy_neg;

  logic                                accept;
  logic [atlr_pkg::COORD_BITS-1:0]     adx, ady;
  logic [atlr_pkg::COORD_BITS-1:0]     ma0, mi0, ma1, mi1;
  logic [atlr_pkg::COORD_BITS-1:0]     maj_lo, maj_hi, min_lo, min_hi;
  logic [atlr_pkg::COORD_BITS-1:0]     dmin_mag, dmaj;
  logic                                steep_in, swap_in, neg_in, point_in;
  logic [atlr_pkg::THICK_BITS-1:0]     thick;
  logic [atlr_pkg::INTENSITY_BITS-1:0] bright;
  logic [atlr_pkg::HALF_BITS-1:0]      hw;
  atlr_pkg::cmd_kind_t                 kind_in;
  logic                                ge;
  logic [atlr_pkg::COORD_BITS:0]       rem_sub;
  logic [atlr_pkg::GRAD_BITS-1:0]      grad_mag;

  assign accept = line_in.valid && line_in.ready;

  always_comb begin
    adx = (line_in.end_x >= line_in.start_x) ? line_in.end_x - line_in.start_x
                                             : line_in.start_x - line_in.end_x;
    ady = (line_in.end_y >= line_in.start_y) ? line_in.end_y - line_in.start_y
                                             : line_in.start_y - line_in.end_y;
    steep_in = ady > adx;
    ma0 = steep_in ? line_in.start_y : line_in.start_x;
    mi0 = steep_in ? line_in.start_x : line_in.start_y;
    ma1 = steep_in ? line_in.end_y : line_in.end_x;
    mi1 = steep_in ? line_in.end_x : line_in.end_y;
    swap_in = ma0 > ma1;
    maj_lo = swap_in ? ma1 : ma0;
    maj_hi = swap_in ? ma0 : ma1;
    min_lo = swap_in ? mi1 : mi0;
    min_hi = swap_in ? mi0 : mi1;
    point_in = maj_lo == maj_hi;
    neg_in = min_hi < min_lo;
    dmin_mag = neg_in ? min_lo - min_hi : min_hi - min_lo;
    dmaj = maj_hi - maj_lo;
    thick = (line_in.width_px > atlr_pkg::THICK_BITS'(atlr_pkg::MAX_THICKNESS))
            ? atlr_pkg::THICK_BITS'(atlr_pkg::MAX_THICKNESS) : line_in.width_px;
    bright = line_in.erase ? atlr_pkg::ALPHA_FULL : line_in.intensity;
    hw = (thick > atlr_pkg::THICK_BITS'(1))
         ? atlr_pkg::HALF_BITS'((thick - atlr_pkg::THICK_BITS'(1)) >> 1) : '0;
    if (line_in.func == atlr_pkg::FUNC_ADVANCE) begin
      kind_in = atlr_pkg::CMD_ADVANCE;
    end else if (bright == '0) begin
      kind_in = atlr_pkg::CMD_DISCARD;
    end else begin
      kind_in = atlr_pkg::CMD_LOAD;
    end
  end

  // One quotient bit per cycle of (|minor delta| * 256) / major delta, restoring form.
  always_comb begin
    ge = rem >= {1'b0, divisor};
    rem_sub = ge ? rem - {1'b0, divisor} : rem;
    grad_mag = atlr_pkg::GRAD_BITS'(quo);
  end

  always_comb begin
    q_cmd = cmd;
    q_cmd.gradient = dy_neg ? -grad_mag : grad_mag;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atlr_pkg::F_IDLE: begin
        if (accept) begin
          if (kind_in == atlr_pkg::CMD_LOAD && !point_in) begin
            state_next = atlr_pkg::F_DIV;
          end else begin
            state_next = atlr_pkg::F_PUSH;
          end
        end
      end
      atlr_pkg::F_DIV: begin
        if (step == atlr_pkg::DIV_CNT_BITS'(atlr_pkg::DIV_STEPS - 1)) begin
          state_next = atlr_pkg::F_PUSH;
        end
      end
      atlr_pkg::F_PUSH: begin
        if (!q_full) begin
          state_next = atlr_pkg::F_IDLE;
        end
      end
      default: state_next = atlr_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    line_in.ready = state == atlr_pkg::F_IDLE;
    q_push = (state == atlr_pkg::F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atlr_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind <= kind_in;
      cmd.steep <= steep_in;
      cmd.point_only <= point_in;
      cmd.column <= maj_lo;
      cmd.last_column <= maj_hi;
      cmd.row_start <= min_lo;
      cmd.gradient <= '0;
      cmd.brightness <= bright;
      cmd.half_width <= hw;
      cmd.erase <= line_in.erase;
      rem <= {1'b0, dmin_mag};
      divisor <= dmaj;
      dy_neg <= neg_in;
      quo <= '0;
      step <= '0;
    end else if (state == atlr_pkg::F_DIV) begin
      rem <= {rem_sub[atlr_pkg::COORD_BITS-1:0], 1'b0};
      quo <= {quo[atlr_pkg::DIV_STEPS-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule

### src/atlr_queue.sv
// Command queue between the front end and the pixel sequencer.
// Depends on atlr_pkg for the command type.
module atlr_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  atlr_pkg::cmd_t    din,
  output logic              full,
  input  logic              pop,
  output atlr_pkg::cmd_t    dout,
  output logic              avail
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  atlr_pkg::cmd_t     entries [DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;

  assign full  = count == CNT_W'(DEPTH);
  assign avail = count != '0;
  assign dout  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail) else $error("pop from empty queue");

endmodule

### src/atlr_back.sv
// Pixel sequencer: holds the active line and walks one column per advance command.
// Depends on atlr_pkg; reads atlr_queue and feeds atlr_emit.
module atlr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  atlr_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              pix_valid,
  output atlr_pkg::pix_t    pix,
  input  logic              pix_ready
);

  atlr_pkg::back_state_t state, state_next;

  logic                                  active;
  logic                                  steep;
  logic                                  point_only;
  logic [atlr_pkg::COORD_BITS-1:0]       column;
  logic [atlr_pkg::COORD_BITS-1:0]       last_column;
  logic [atlr_pkg::ROW_BITS-1:0]         row_fixed;
  logic signed [atlr_pkg::GRAD_BITS-1:0] gradient;
  logic [atlr_pkg::INTENSITY_BITS-1:0]   bright;
  logic [atlr_pkg::HALF_BITS-1:0]        hw;
  logic                                  erase_mode;
  logic [atlr_pkg::OFS_BITS-1:0]         cnt_a, cnt_b;

  logic [atlr_pkg::COORD_BITS-1:0]       yi;
  logic [atlr_pkg::FRAC_BITS-1:0]        frac;
  logic [atlr_pkg::OFS_BITS-1:0]         span, line_end;
  logic                                  pix_last, col_done, pix_done, fire;
  logic                                  is_top, is_edge;
  logic [atlr_pkg::FRAC_BITS-1:0]        weight;
  logic [2*atlr_pkg::INTENSITY_BITS-1:0] prod;
  logic [atlr_pkg::PIX_BITS-1:0]         base_minor, minor, major, pt_x, pt_y;
  atlr_pkg::pix_t                        pix_calc;

  always_comb begin
    yi = row_fixed[atlr_pkg::ROW_BITS-1:atlr_pkg::FRAC_BITS];
    frac = row_fixed[atlr_pkg::FRAC_BITS-1:0];
    span = {hw, 1'b0};
    line_end = (frac != '0) ? span + 1'b1 : span;
    if (point_only) begin
      pix_last = (cnt_a == span) && (cnt_b == span);
    end else begin
      pix_last = cnt_a == line_end;
    end
    col_done = column >= last_column;
    pix_done = pix_last && (point_only || col_done);
    fire = (state == atlr_pkg::B_EMIT) && (!pix_valid || pix_ready);

    is_top = cnt_a == '0;
    is_edge = !point_only && (is_top || (cnt_a == span + 1'b1));
    weight = is_top ? atlr_pkg::ALPHA_FULL - frac : frac;
    prod = (2*atlr_pkg::INTENSITY_BITS)'(bright) * (2*atlr_pkg::INTENSITY_BITS)'(weight);

    base_minor = atlr_pkg::PIX_BITS'(yi) - atlr_pkg::PIX_BITS'(hw);
    minor = base_minor + atlr_pkg::PIX_BITS'(cnt_a);
    major = atlr_pkg::PIX_BITS'(column);
    pt_x = major - atlr_pkg::PIX_BITS'(hw) + atlr_pkg::PIX_BITS'(cnt_a);
    pt_y = base_minor + atlr_pkg::PIX_BITS'(cnt_b);

    if (point_only) begin
      pix_calc.x = pt_x;
      pix_calc.y = pt_y;
    end else if (steep) begin
      pix_calc.x = minor;
      pix_calc.y = major;
    end else begin
      pix_calc.x = major;
      pix_calc.y = minor;
    end
    pix_calc.alpha = is_edge ? prod[2*atlr_pkg::INTENSITY_BITS-1:atlr_pkg::INTENSITY_BITS]
                             : bright;
    pix_calc.erase = erase_mode;
    pix_calc.last = pix_last;
    pix_calc.done = pix_done;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atlr_pkg::B_FETCH: begin
        if (q_avail && q_cmd.kind == atlr_pkg::CMD_ADVANCE && active) begin
          state_next = atlr_pkg::B_EMIT;
        end
      end
      atlr_pkg::B_EMIT: begin
        if (fire && pix_last) begin
          state_next = atlr_pkg::B_FETCH;
        end
      end
      default: state_next = atlr_pkg::B_FETCH;
    endcase
  end

  always_comb begin
    q_pop = (state == atlr_pkg::B_FETCH) && q_avail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atlr_pkg::B_FETCH;
      active <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        case (q_cmd.kind)
          atlr_pkg::CMD_LOAD:    active <= 1'b1;
          atlr_pkg::CMD_DISCARD: active <= 1'b0;
          default: ;
        endcase
      end else if (fire && pix_done) begin
        active <= 1'b0;
      end
      if (fire) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == atlr_pkg::CMD_LOAD) begin
      steep <= q_cmd.steep;
      point_only <= q_cmd.point_only;
      column <= q_cmd.column;
      last_column <= q_cmd.last_column;
      row_fixed <= {q_cmd.row_start, {atlr_pkg::FRAC_BITS{1'b0}}};
      gradient <= q_cmd.gradient;
      bright <= q_cmd.brightness;
      hw <= q_cmd.half_width;
      erase_mode <= q_cmd.erase;
    end else if (fire && pix_last && !pix_done) begin
      column <= column + 1'b1;
      row_fixed <= row_fixed + {{(atlr_pkg::ROW_BITS - atlr_pkg::GRAD_BITS)
                                 {gradient[atlr_pkg::GRAD_BITS-1]}}, gradient};
    end
    if (q_pop) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (fire) begin
      if (point_only && cnt_a == span) begin
        cnt_a <= '0;
        cnt_b <= cnt_b + 1'b1;
      end else begin
        cnt_a <= cnt_a + 1'b1;
      end
    end
    if (fire) begin
      pix <= pix_calc;
    end
  end

  a_emit_active: assert property (@(posedge clk) disable iff (rst)
    state == atlr_pkg::B_EMIT |-> active) else $error("emitting without a line");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.done |-> pix.last) else $error("line end not on column end");
  a_point_ends: assert property (@(posedge clk) disable iff (rst)
    fire && pix_last && point_only |=> !active) else $error("point left line active");

endmodule

### src/atlr_emit.sv
// Output stage: frame clipping flag, framebuffer address and the pixel output register.
// Depends on atlr_pkg and atlr_pixel_if; fed by atlr_back.
module atlr_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  input  atlr_pkg::pix_t                  pix,
  output logic                            pix_ready,
  input  logic [atlr_pkg::CFG_BITS-1:0]   frame_width,
  input  logic [atlr_pkg::CFG_BITS-1:0]   frame_height,
  atlr_pixel_if.source                    pixels
);

  localparam int PROD_BITS = 2 * atlr_pkg::CFG_BITS;

  logic                              out_valid;
  logic [atlr_pkg::CFG_BITS-1:0]     ux, uy;
  logic                              in_frame_calc;
  logic [PROD_BITS-1:0]              row_base, addr_full;
  logic [atlr_pkg::ADDR_BITS-1:0]    addr_calc;

  always_comb begin
    ux = pix.x[atlr_pkg::CFG_BITS-1:0];
    uy = pix.y[atlr_pkg::CFG_BITS-1:0];
    in_frame_calc = !pix.x[atlr_pkg::PIX_BITS-1] && !pix.y[atlr_pkg::PIX_BITS-1] &&
                    (ux < frame_width) && (uy < frame_height);
    row_base = PROD_BITS'(uy) * PROD_BITS'(frame_width);
    addr_full = row_base + PROD_BITS'(ux);
    addr_calc = in_frame_calc ? addr_full[atlr_pkg::ADDR_BITS-1:0] : '0;
  end

  assign pix_ready = !out_valid || pixels.ready;
  assign pixels.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_ready) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      pixels.pixel_x <= pix.x;
      pixels.pixel_y <= pix.y;
      pixels.pixel_address <= addr_calc;
      pixels.in_frame <= in_frame_calc;
      pixels.alpha <= pix.alpha;
      pixels.erase_pixel <= pix.erase;
      pixels.last <= pix.last;
      pixels.line_done <= pix.done;
    end
  end

endmodule
